// ----- sv/fgp_pkg.sv -----
// Shared constants, types and the exponent table of the film grain pixel pipeline.
package fgp_pkg;

	localparam int COORD_BITS_DEF  = 13;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SCALE_W = 23;
	localparam int SEED_W  = 31;
	localparam int AMT_W   = 16;
	localparam int CFG_W   = 31;

	localparam int HASH_LAT = 7;
	localparam int DX_W     = 20;
	localparam int SQ_W     = 2 * DX_W;
	localparam int ROOT_W   = DX_W;

	localparam logic [31:0] HASH_MUL = 32'd12829;
	localparam logic [31:0] HASH_ADD = 32'd47989;
	localparam logic signed [31:0] F2_S = 32'sd1572067139;
	localparam logic [30:0] F2_U = 31'd1572067139;
	localparam logic signed [31:0] G2_S = 32'sd907633386;

	typedef enum logic [1:0] {
		CFG_SEED_FROM_FRAME = 2'd0,
		CFG_FIXED_SEED      = 2'd1,
		CFG_GRAIN_AMOUNT    = 2'd2,
		CFG_INVERSE_SCALE   = 2'd3
	} cfg_idx_t;

	// 2^(-k/16) in Q.16 for k = 0..16.
	function automatic logic [16:0] exp_tab(input logic [4:0] idx);
		logic [16:0] val;
		case (idx)
			5'd0: val = 17'd65536;
			5'd1: val = 17'd62757;
			5'd2: val = 17'd60097;
			5'd3: val = 17'd57549;
			5'd4: val = 17'd55109;
			5'd5: val = 17'd52773;
			5'd6: val = 17'd50535;
			5'd7: val = 17'd48393;
			5'd8: val = 17'd46341;
			5'd9: val = 17'd44376;
			5'd10: val = 17'd42495;
			5'd11: val = 17'd40693;
			5'd12: val = 17'd38968;
			5'd13: val = 17'd37316;
			5'd14: val = 17'd35734;
			5'd15: val = 17'd34219;
			5'd16: val = 17'd32768;
			default: val = 17'd0;
		endcase
		return val;
	endfunction

endpackage

// ----- sv/fgp_hash.sv -----
// Pipelined multiply-add hash of three 32-bit lanes to 16 bits each.
module fgp_hash (
	input  logic             clk,
	input  logic [2:0][31:0] seed_vec,
	output logic [2:0][15:0] hashed
);
	import fgp_pkg::*;

	logic [2:0][31:0] hv_s [HASH_LAT];

	always_ff @(posedge clk) begin
		for (int m = 0; m < 3; m++) begin
			hv_s[0][m] <= 32'(seed_vec[m] * HASH_MUL) + HASH_ADD;
		end
	end

	// Each later stage updates one lane from the product of the other two.
	for (genvar k = 1; k < HASH_LAT; k++) begin : g_round
		localparam int J = (k - 1) % 3;
		localparam int P = (J + 1) % 3;
		localparam int Q = (J + 2) % 3;
		always_ff @(posedge clk) begin
			for (int m = 0; m < 3; m++) begin
				if (m == J) begin
					hv_s[k][m] <= hv_s[k-1][m] + 32'(hv_s[k-1][P] * hv_s[k-1][Q]);
				end else begin
					hv_s[k][m] <= hv_s[k-1][m];
				end
			end
		end
	end

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			hashed[m] = hv_s[HASH_LAT-1][m][31:16];
		end
	end

endmodule

// ----- sv/fgp_isqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
module fgp_isqrt (
	input  logic                      clk,
	input  logic [fgp_pkg::SQ_W-1:0]  radicand,
	output logic [fgp_pkg::ROOT_W-1:0] root
);
	import fgp_pkg::*;

	logic [SQ_W-1:0] rem_s [ROOT_W];
	logic [SQ_W-1:0] acc_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
		logic [SQ_W-1:0] rem_in;
		logic [SQ_W-1:0] acc_in;
		logic [SQ_W-1:0] trial;

		if (i == 0) begin : g_first
			assign rem_in = radicand;
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign acc_in = acc_s[i-1];
		end

		assign trial = acc_in + BIT;

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_s[i] <= rem_in - trial;
				acc_s[i] <= (acc_in >> 1) + BIT;
			end else begin
				rem_s[i] <= rem_in;
				acc_s[i] <= acc_in >> 1;
			end
		end
	end

	assign root = acc_s[ROOT_W-1][ROOT_W-1:0];

endmodule

// ----- sv/film_grain_pixel.sv -----
// Top level of the film grain pipeline for one RGB pixel per clock.
//
// A pixel word (coordinates, frame number, three samples) is taken at each
// rising edge where start is high and busy is low. busy is never raised, so
// a new word may enter in every cycle. The matching result appears on
// red_out, green_out and blue_out with done high for exactly one cycle.
// Results leave in the order the words arrived, one per cycle at most.
// The pipeline is the chain of the coordinate multiply, seven hash
// stages, the lattice arithmetic, a twenty-stage square root and the
// per-channel multiplies.
// The receiver cannot stall the block; it must take every word on done.
// Registers are written through wr_en, wr_index and wr_data, and are to be
// changed only when no pixel is in flight.
// Asynchronous reset clears the valid pipeline, so no done is issued for
// words in flight, and returns the registers to their defaults: frame seed
// on, fixed seed zero, amount 102 and inverse scale 1.0.
module film_grain_pixel #(
	parameter int COORD_BITS  = fgp_pkg::COORD_BITS_DEF,
	parameter int SAMPLE_BITS = fgp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [COORD_BITS-1:0]       pixel_x,
	input  logic [COORD_BITS-1:0]       pixel_y,
	input  logic [31:0]                 frame_number,
	input  logic [15:0]                 red_in,
	input  logic [15:0]                 green_in,
	input  logic [15:0]                 blue_in,
	output logic                        done,
	output logic [15:0]                 red_out,
	output logic [15:0]                 green_out,
	output logic [15:0]                 blue_out,
	input  logic                        wr_en,
	input  fgp_pkg::cfg_idx_t           wr_index,
	input  logic [fgp_pkg::CFG_W-1:0]   wr_data
);
	import fgp_pkg::*;

	localparam int NST   = 42;
	localparam int SB    = SAMPLE_BITS;
	localparam int XS_W  = COORD_BITS + SCALE_W;
	localparam int PX_W  = XS_W + 2;
	localparam int SUM_W = XS_W + 3;
	localparam int SH_W  = SUM_W - 16;
	localparam int MUL_W = SUM_W + 16;
	localparam int U_W   = SUM_W + 17;
	localparam int A_W   = XS_W + 21;
	localparam int IX_W  = A_W - 32;
	localparam int V_W   = IX_W + 33;
	localparam int VR_W  = V_W - 16;
	localparam int EX_W  = XS_W + 6;
	localparam int G_W   = (EX_W > VR_W ? EX_W : VR_W) + 1;
	localparam int T_W   = ROOT_W + 2;
	localparam int P1_W  = SB + 18;
	localparam int P2_W  = P1_W + 17;
	localparam int D_W   = P2_W - 27;
	localparam int R_W   = D_W + 1;

	localparam logic [15:0] MAXV16 = 16'((1 << SB) - 1);
	localparam logic [SB-1:0] MAXV = SB'((1 << SB) - 1);
	localparam logic signed [A_W-1:0] HALF_UP = A_W'(64'sd2147483648);
	localparam logic signed [A_W-1:0] HALF_DN = A_W'(64'sd2147483647);

	// Configuration registers.
	logic                 seed_from_frame_q;
	logic [SEED_W-1:0]    fixed_seed_q;
	logic [AMT_W-1:0]     grain_amount_q;
	logic [SCALE_W-1:0]   inverse_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_from_frame_q <= 1'b1;
			fixed_seed_q      <= '0;
			grain_amount_q    <= AMT_W'(102);
			inverse_scale_q   <= SCALE_W'(65536);
		end else if (wr_en) begin
			case (wr_index)
				CFG_SEED_FROM_FRAME: seed_from_frame_q <= wr_data[0];
				CFG_FIXED_SEED:      fixed_seed_q <= wr_data[SEED_W-1:0];
				CFG_GRAIN_AMOUNT:    grain_amount_q <= wr_data[AMT_W-1:0];
				CFG_INVERSE_SCALE:   inverse_scale_q <= wr_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Valid bits travel with the words.
	logic vld_s [1:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Samples are clamped and their headroom found on entry.
	logic [2:0][15:0]   rgb_in;
	logic [2:0][SB-1:0] smp_n;
	logic [2:0][SB-1:0] lim_n;
	logic [2:0][SB-1:0] smp_s [1:NST-1];
	logic [2:0][SB-1:0] lim_s [1:NST-3];

	assign rgb_in = {blue_in, green_in, red_in};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			smp_n[c] = (rgb_in[c] > MAXV16) ? MAXV : rgb_in[c][SB-1:0];
			lim_n[c] = (smp_n[c] < MAXV - smp_n[c]) ? smp_n[c] : MAXV - smp_n[c];
		end
	end

	always_ff @(posedge clk) begin
		smp_s[1] <= smp_n;
		lim_s[1] <= lim_n;
		for (int k = 2; k <= NST - 1; k++) begin
			smp_s[k] <= smp_s[k-1];
		end
		for (int k = 2; k <= NST - 3; k++) begin
			lim_s[k] <= lim_s[k-1];
		end
	end

	// Stage 1: coarse positions and the seed.
	logic [XS_W-1:0] xs_s [1:8];
	logic [XS_W-1:0] ys_s [1:8];
	logic [31:0]     seed_s1;

	always_ff @(posedge clk) begin
		xs_s[1] <= XS_W'(pixel_x) * XS_W'(inverse_scale_q);
		ys_s[1] <= XS_W'(pixel_y) * XS_W'(inverse_scale_q);
		seed_s1 <= seed_from_frame_q ? frame_number : {1'b0, fixed_seed_q};
		for (int k = 2; k <= 8; k++) begin
			xs_s[k] <= xs_s[k-1];
			ys_s[k] <= ys_s[k-1];
		end
	end

	// Stages 2 to 8: hash of the cell and seed.
	logic [2:0][31:0] hash_vec;
	logic [2:0][15:0] hashed;

	assign hash_vec[0] = 32'(xs_s[1] >> 13);
	assign hash_vec[1] = 32'(ys_s[1] >> 13);
	assign hash_vec[2] = seed_s1;

	fgp_hash u_hash (
		.clk      (clk),
		.seed_vec (hash_vec),
		.hashed   (hashed)
	);

	// Stage 9: jittered position and the skew sum.
	logic signed [PX_W-1:0]  px_s9, py_s9, px_s10, py_s10, px_s11, py_s11;
	logic signed [PX_W-1:0]  px_s12, py_s12, px_s13, py_s13;
	logic signed [SUM_W-1:0] sum_s9;

	always_ff @(posedge clk) begin
		px_s9 <= PX_W'($signed({1'b0, xs_s[8]})) + PX_W'($signed({1'b0, hashed[0]}))
			- PX_W'(32768);
		py_s9 <= PX_W'($signed({1'b0, ys_s[8]})) + PX_W'($signed({1'b0, hashed[1]}))
			- PX_W'(32768);
		sum_s9 <= SUM_W'($signed({1'b0, xs_s[8]})) + SUM_W'($signed({1'b0, ys_s[8]}))
			+ SUM_W'($signed({1'b0, hashed[0]})) + SUM_W'($signed({1'b0, hashed[1]}))
			- SUM_W'(65536);
		px_s10 <= px_s9;
		py_s10 <= py_s9;
		px_s11 <= px_s10;
		py_s11 <= py_s10;
		px_s12 <= px_s11;
		py_s12 <= py_s11;
		px_s13 <= px_s12;
		py_s13 <= py_s12;
	end

	// Stage 10: the skew product, split at bit 16 of the sum.
	logic signed [SH_W-1:0]  sh;
	logic [15:0]             sl;
	logic signed [MUL_W-1:0] mulh_s10;
	logic [46:0]             mull_s10;

	assign sh = sum_s9[SUM_W-1:16];
	assign sl = sum_s9[15:0];

	always_ff @(posedge clk) begin
		mulh_s10 <= MUL_W'(sh * F2_S);
		mull_s10 <= 47'(sl * F2_U);
	end

	// Stages 11 and 12: skew u and the skewed positions.
	logic signed [U_W-1:0] u_s11;
	logic signed [A_W-1:0] ax_s12, ay_s12;

	always_ff @(posedge clk) begin
		u_s11 <= U_W'(mulh_s10) + U_W'($signed({1'b0, mull_s10[46:16]}));
		ax_s12 <= (A_W'(px_s11) <<< 16) + A_W'(u_s11);
		ay_s12 <= (A_W'(py_s11) <<< 16) + A_W'(u_s11);
	end

	// Stage 13: lattice point, rounded half away from zero in one add.
	logic signed [A_W-1:0]  axb, ayb;
	logic signed [IX_W-1:0] ix_s13, iy_s13;

	assign axb = ax_s12 + (ax_s12[A_W-1] ? HALF_DN : HALF_UP);
	assign ayb = ay_s12 + (ay_s12[A_W-1] ? HALF_DN : HALF_UP);

	always_ff @(posedge clk) begin
		ix_s13 <= axb[A_W-1:32];
		iy_s13 <= ayb[A_W-1:32];
	end

	// Stage 14: unskew term and the integer part of the offset.
	logic signed [V_W-1:0]  v_s14;
	logic signed [EX_W-1:0] ex_s14, ey_s14;

	always_ff @(posedge clk) begin
		v_s14  <= V_W'((V_W'(ix_s13) + V_W'(iy_s13)) * G2_S);
		ex_s14 <= EX_W'(px_s13) - (EX_W'(ix_s13) <<< 16);
		ey_s14 <= EX_W'(py_s13) - (EX_W'(iy_s13) <<< 16);
	end

	// Stage 15: offset in Q.16, rounded half up.
	logic signed [V_W-1:0]  vr_full;
	logic signed [VR_W-1:0] vr;
	logic signed [G_W-1:0]  dx_w, dy_w;
	logic signed [DX_W-1:0] dx_s15, dy_s15;

	assign vr_full = v_s14 + V_W'(32768);
	assign vr      = vr_full[V_W-1:16];
	assign dx_w    = G_W'(ex_s14) + G_W'(vr);
	assign dy_w    = G_W'(ey_s14) + G_W'(vr);

	always_ff @(posedge clk) begin
		dx_s15 <= dx_w[DX_W-1:0];
		dy_s15 <= dy_w[DX_W-1:0];
	end

	// Stages 16 and 17: squared length.
	logic signed [SQ_W-1:0] sqx_s16, sqy_s16;
	logic [SQ_W-1:0]        n_s17;

	always_ff @(posedge clk) begin
		sqx_s16 <= SQ_W'(dx_s15) * SQ_W'(dx_s15);
		sqy_s16 <= SQ_W'(dy_s15) * SQ_W'(dy_s15);
		n_s17   <= SQ_W'(sqx_s16) + SQ_W'(sqy_s16);
	end

	// Stages 18 to 37: length.
	logic [ROOT_W-1:0] root_s37;

	fgp_isqrt u_isqrt (
		.clk      (clk),
		.radicand (n_s17),
		.root     (root_s37)
	);

	// Stage 38: table lookup and interpolation product for exp2(-3L).
	logic [T_W-1:0] t_n;
	logic [16:0]    tab0, tab1;
	logic [16:0]    tab0_s38;
	logic [23:0]    prod_s38;
	logic [T_W-17:0] ip_s38;

	assign t_n  = T_W'(root_s37) + (T_W'(root_s37) << 1);
	assign tab0 = exp_tab({1'b0, t_n[15:12]});
	assign tab1 = exp_tab(5'({1'b0, t_n[15:12]}) + 5'd1);

	always_ff @(posedge clk) begin
		tab0_s38 <= tab0;
		prod_s38 <= 24'((tab0 - tab1) * 17'(t_n[11:0]));
		ip_s38   <= t_n[T_W-1:16];
	end

	// Stage 39: grain in Q.16, between -1 and 1.
	logic [16:0]         e_n, es_n;
	logic signed [17:0]  grain_s39;

	assign e_n  = tab0_s38 - 17'(prod_s38 >> 12);
	assign es_n = (ip_s38 >= (T_W-16)'(17)) ? 17'd0 : (e_n >> ip_s38);

	always_ff @(posedge clk) begin
		grain_s39 <= 18'(19'sd65536 - $signed({1'b0, es_n, 1'b0}));
	end

	// Stages 40 to 42: per-channel change, rounding and saturation.
	logic signed [P1_W-1:0] p1_s40 [3];
	logic signed [P2_W-1:0] p2_s41 [3];
	logic signed [P2_W-1:0] p2r [3];
	logic signed [D_W-1:0]  dd [3];
	logic signed [R_W-1:0]  rr [3];
	logic [2:0][SB-1:0]     res_n;
	logic [2:0][SB-1:0]     out_s42;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			p2r[c] = p2_s41[c] + P2_W'(64'sd67108864);
			dd[c]  = p2r[c][P2_W-1:27];
			rr[c]  = R_W'(dd[c]) + R_W'($signed({1'b0, smp_s[NST-1][c]}));
			if (rr[c] < 0) begin
				res_n[c] = '0;
			end else if (rr[c] > R_W'($signed({1'b0, MAXV}))) begin
				res_n[c] = MAXV;
			end else begin
				res_n[c] = rr[c][SB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			p1_s40[c] <= P1_W'(grain_s39) * P1_W'($signed({1'b0, lim_s[NST-3][c]}));
			p2_s41[c] <= P2_W'(p1_s40[c]) * P2_W'($signed({1'b0, grain_amount_q}));
		end
		out_s42 <= res_n;
	end

	assign done      = vld_s[NST];
	assign red_out   = 16'(out_s42[0]);
	assign green_out = 16'(out_s42[1]);
	assign blue_out  = 16'(out_s42[2]);

`ifndef SYNTH
	// Every result word traces back to a word taken the full latency earlier.
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, NST))
		else $error("done without a matching accepted word");

	// The shaped grain stays within -1.0 .. 1.0 in Q.16.
	a_grain_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[39] |-> (grain_s39 >= -18'sd65536 && grain_s39 <= 18'sd65536))
		else $error("grain outside -1.0 .. 1.0");

	// A word leaves at most once: a valid bit never stays in the last stage twice unless fed.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done)) |-> $past(vld_s[NST-1]))
		else $error("result word repeated");
`endif

endmodule

// ----- tb/film_grain_pixel_test.sv -----
// Self-checking testbench of the film grain pixel block with its own predictor.
`timescale 1ns / 1ps

module film_grain_pixel_test;
	import fgp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PIPE_DRAIN  = 60;
	localparam longint SAMPLE_MAX = 65535;
	localparam longint F2_Q = 64'sd1572067139;
	localparam longint G2_Q = 64'sd907633386;
	localparam longint POW_TAB [0:16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
		48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} rgb_t;

	logic        clk, arst_n, start, busy, done, wr_en;
	logic [12:0] pixel_x, pixel_y;
	logic [31:0] frame_number;
	logic [15:0] red_in, green_in, blue_in, red_out, green_out, blue_out;
	cfg_idx_t    wr_index;
	logic [CFG_W-1:0] wr_data;

	// Mirror of the register file.
	logic        m_seed_from_frame;
	logic [30:0] m_fixed_seed;
	logic [15:0] m_amount;
	logic [22:0] m_inv_scale;

	rgb_t expected_pixels[$];
	int   fail_count = 0;
	int   cycles = 0;
	bit   gaps_on;

	film_grain_pixel dut (
		.clk, .arst_n, .start, .busy, .pixel_x, .pixel_y, .frame_number,
		.red_in, .green_in, .blue_in, .done, .red_out, .green_out, .blue_out,
		.wr_en, .wr_index, .wr_data
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint pow2_neg(input longint t);
		longint ip, f, idx, w, e;
		ip = t >>> 16;
		f = t & 64'hFFFF;
		idx = f >>> 12;
		w = f & 64'hFFF;
		e = POW_TAB[idx] - (((POW_TAB[idx] - POW_TAB[idx + 1]) * w) >>> 12);
		if (ip >= 17)
			return 0;
		return e >>> ip;
	endfunction

	// Grain value in Q.16 for one pixel position, in [-1, 1].
	function automatic longint grain_at(input logic [12:0] xc, input logic [12:0] yc,
			input logic [31:0] frame);
		logic [31:0] ha, hb, hc;
		longint xs, ys, px, py, sum, sh, sl, u, ix, iy, v, dx, dy, a;
		longint unsigned len;
		xs = longint'(xc) * longint'(m_inv_scale);
		ys = longint'(yc) * longint'(m_inv_scale);
		ha = 32'(xs >> 13);
		hb = 32'(ys >> 13);
		hc = m_seed_from_frame ? frame : {1'b0, m_fixed_seed};
		ha = ha * HASH_MUL + HASH_ADD;
		hb = hb * HASH_MUL + HASH_ADD;
		hc = hc * HASH_MUL + HASH_ADD;
		repeat (2) begin
			ha = ha + hb * hc;
			hb = hb + hc * ha;
			hc = hc + ha * hb;
		end
		px = xs + longint'(ha >> 16) - 32768;
		py = ys + longint'(hb >> 16) - 32768;
		sum = px + py;
		sh = sum >>> 16;
		sl = sum & 64'hFFFF;
		u = sh * F2_Q + ((sl * F2_Q) >>> 16);
		a = px * 65536 + u;
		ix = (a >= 0) ? ((a + 64'sh80000000) >>> 32) : -((-a + 64'sh80000000) >>> 32);
		a = py * 65536 + u;
		iy = (a >= 0) ? ((a + 64'sh80000000) >>> 32) : -((-a + 64'sh80000000) >>> 32);
		v = (ix + iy) * G2_Q;
		dx = (px * 65536 - (ix <<< 32) + v + 32768) >>> 16;
		dy = (py * 65536 - (iy <<< 32) + v + 32768) >>> 16;
		len = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
		return 65536 - 2 * pow2_neg(3 * longint'(len));
	endfunction

	function automatic logic [15:0] grained_sample(input longint grain, input logic [15:0] smp);
		longint s, lim, r;
		s = smp;
		lim = (s < SAMPLE_MAX - s) ? s : SAMPLE_MAX - s;
		r = s + ((grain * lim * longint'(m_amount) + (64'sd1 <<< 26)) >>> 27);
		if (r < 0)
			r = 0;
		if (r > SAMPLE_MAX)
			r = SAMPLE_MAX;
		return r[15:0];
	endfunction

	task automatic random_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [12:0] xc, input logic [12:0] yc,
			input logic [31:0] frame, input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b);
		longint grain;
		rgb_t exp_px;
		random_gap();
		start        <= 1'b1;
		pixel_x      <= xc;
		pixel_y      <= yc;
		frame_number <= frame;
		red_in       <= r;
		green_in     <= g;
		blue_in      <= b;
		do
			@(posedge clk);
		while (busy);
		grain = grain_at(xc, yc, frame);
		exp_px.red   = grained_sample(grain, r);
		exp_px.green = grained_sample(grain, g);
		exp_px.blue  = grained_sample(grain, b);
		expected_pixels.push_back(exp_px);
	endtask

	task automatic send_random_pixel();
		send_pixel(13'($urandom), 13'($urandom), $urandom, 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// Registers change only once the pipeline is empty.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		start <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_SEED_FROM_FRAME: m_seed_from_frame = val[0];
			CFG_FIXED_SEED:      m_fixed_seed = val[30:0];
			CFG_GRAIN_AMOUNT:    m_amount = val[15:0];
			CFG_INVERSE_SCALE:   m_inv_scale = val[22:0];
			default: ;
		endcase
	endtask

	// Each word on done is taken at the edge that closes its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected word red %0d green %0d blue %0d",
					$time, red_out, green_out, blue_out);
				fail_count++;
			end else begin
				rgb_t e;
				e = expected_pixels.pop_front();
				if (red_out !== e.red) begin
					$display("%0t: red expected %0d actual %0d", $time, e.red, red_out);
					fail_count++;
				end
				if (green_out !== e.green) begin
					$display("%0t: green expected %0d actual %0d", $time, e.green, green_out);
					fail_count++;
				end
				if (blue_out !== e.blue) begin
					$display("%0t: blue expected %0d actual %0d", $time, e.blue, blue_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("film_grain_pixel regression: fail");
			$finish;
		end
	end

	task automatic test_sample_extremes();
		send_pixel(0, 0, 0, 0, 65535, 32767);
		send_pixel(8191, 8191, 32'hFFFFFFFF, 32768, 1, 65534);
		send_pixel(8191, 0, 32'h55555555, 65535, 0, 12345);
		send_pixel(0, 8191, 32'hAAAAAAAA, 1, 32768, 32767);
		send_pixel(13'h1555, 13'h0AAA, 7, 20000, 45000, 32767);
		send_pixel(13'h0AAA, 13'h1555, 8, 65535, 65535, 0);
	endtask

	task automatic test_fixed_seed();
		write_reg(CFG_SEED_FROM_FRAME, 0);
		write_reg(CFG_FIXED_SEED, 31'h7FFFFFFF);
		send_pixel(100, 200, 1, 30000, 40000, 50000);
		send_pixel(100, 200, 2, 30000, 40000, 50000);
		write_reg(CFG_FIXED_SEED, 31'h2AAAAAAA);
		send_random_pixel();
		write_reg(CFG_SEED_FROM_FRAME, 1);
		send_random_pixel();
	endtask

	task automatic test_amount_extremes();
		write_reg(CFG_GRAIN_AMOUNT, 0);
		send_random_pixel();
		send_pixel(50, 60, 3, 32767, 32768, 1000);
		write_reg(CFG_GRAIN_AMOUNT, 40960);
		send_random_pixel();
		send_pixel(50, 60, 3, 32767, 32768, 1000);
		write_reg(CFG_GRAIN_AMOUNT, CFG_W'(16'hFFFF));
		send_pixel(51, 61, 4, 32767, 32768, 1000);
		write_reg(CFG_GRAIN_AMOUNT, 102);
	endtask

	task automatic test_scale_extremes();
		write_reg(CFG_INVERSE_SCALE, 0);
		send_random_pixel();
		write_reg(CFG_INVERSE_SCALE, 3277);
		send_random_pixel();
		write_reg(CFG_INVERSE_SCALE, 6553600);
		send_pixel(8191, 8191, 9, 30000, 31000, 32000);
		write_reg(CFG_INVERSE_SCALE, CFG_W'(23'h7FFFFF));
		send_pixel(8191, 8191, 10, 30000, 31000, 32000);
	endtask

	task automatic test_random_settings();
		repeat (6) begin
			write_reg(CFG_SEED_FROM_FRAME, CFG_W'($urandom_range(0, 1)));
			write_reg(CFG_FIXED_SEED, CFG_W'($urandom));
			write_reg(CFG_GRAIN_AMOUNT, CFG_W'($urandom_range(0, 40960)));
			write_reg(CFG_INVERSE_SCALE, CFG_W'($urandom_range(3277, 6553600)));
			repeat (80) send_random_pixel();
		end
		// The last stretch streams back to back.
		gaps_on = 1'b0;
		repeat (120) send_random_pixel();
		start <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_SEED_FROM_FRAME;
		wr_data = '0;
		pixel_x = '0;
		pixel_y = '0;
		frame_number = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		m_seed_from_frame = 1'b1;
		m_fixed_seed = '0;
		m_amount = 16'd102;
		m_inv_scale = 23'd65536;
		gaps_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sample_extremes();
		test_fixed_seed();
		test_amount_extremes();
		test_scale_extremes();
		test_random_settings();

		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("film_grain_pixel regression: pass");
		else
			$display("film_grain_pixel regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
sv/fgp_pkg.sv
sv/fgp_hash.sv
sv/fgp_isqrt.sv
sv/film_grain_pixel.sv
tb/film_grain_pixel_test.sv
